// ----- design/tor_pkg.sv -----
// tor_pkg: byte codes, option list and parser state type for the telnet option responder
// no dependencies

package tor_pkg;

    localparam logic [7:0] TN_IAC  = 8'd255;
    localparam logic [7:0] TN_DONT = 8'd254;
    localparam logic [7:0] TN_DO   = 8'd253;
    localparam logic [7:0] TN_WONT = 8'd252;
    localparam logic [7:0] TN_WILL = 8'd251;
    localparam logic [7:0] TN_ESC  = 8'd27;

    localparam logic [7:0] OPT_TTYPE     = 8'd24;
    localparam logic [7:0] OPT_NAWS      = 8'd31;
    localparam logic [7:0] OPT_TSPEED    = 8'd32;
    localparam logic [7:0] OPT_XDISPLOC  = 8'd35;
    localparam logic [7:0] OPT_ENVIRON   = 8'd36;
    localparam logic [7:0] OPT_NEWENVIRON = 8'd39;

    localparam int REPLY_LEN = 3;
    localparam int SEQ_W = $clog2(REPLY_LEN);

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    typedef enum logic [3:0] {
        PH_DATA = 4'b0001,
        PH_CMD  = 4'b0010,
        PH_OPT  = 4'b0100,
        PH_ESC  = 4'b1000
    } phase_t;

    function automatic logic option_refused(input logic [7:0] opt);
        return (opt == OPT_TTYPE) || (opt == OPT_NAWS) || (opt == OPT_TSPEED) ||
               (opt == OPT_XDISPLOC) || (opt == OPT_ENVIRON) || (opt == OPT_NEWENVIRON);
    endfunction

endpackage

// ----- design/telnet_option_responder_core.sv -----
// telnet_option_responder_core: byte parser that forwards data and answers option requests
// depends on tor_pkg
//
// channel | ports                                  | word
// --------+----------------------------------------+------------------------------------
// input   | s_valid s_ready s_in_byte              | one received byte
// result  | m_valid m_ready m_out_kind/byte/last   | one data byte or one reply byte
//
// a byte is registered on input, parsed in the next cycle and loaded into the result register
// data bytes leave one word per cycle while m_ready is high; a reply holds the result register for its three words
// bytes that give no word (command, esc and swallowed bytes) retire without waiting, even under stall
// input stalls only while a parsed byte waits for the result register to drain
// reset is synchronous active low and returns the parser to plain data

module telnet_option_responder_core
    import tor_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_out_kind,
    output logic [7:0] m_out_byte,
    output logic       m_out_last
);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    phase_t           phase_reg, phase_next;
    logic [7:0]       cmd_reg, cmd_next;

    logic             out_valid_reg, out_valid_next;
    logic             kind_reg;
    logic [7:0]       byte_reg;
    logic [7:0]       answer_reg;
    logic [SEQ_W-1:0] seq_reg, seq_next;

    logic             has_result;
    logic             res_kind;
    logic [7:0]       res_answer;
    logic             out_free;
    logic             consume;
    logic             load;

    // parse the registered byte
    always_comb begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        has_result = 1'b0;
        res_kind   = KIND_DATA;
        res_answer = TN_WILL;
        case (phase_reg)
            PH_CMD: begin
                cmd_next   = in_byte_reg;
                phase_next = PH_OPT;
            end
            PH_OPT: begin
                phase_next = PH_DATA;
                res_kind   = KIND_REPLY;
                if (cmd_reg == TN_DO || cmd_reg == TN_DONT) begin
                    has_result = 1'b1;
                    res_answer = (cmd_reg == TN_DONT || option_refused(in_byte_reg))
                               ? TN_WONT : TN_WILL;
                end else if (cmd_reg == TN_WILL) begin
                    has_result = 1'b1;
                    res_answer = TN_DO;
                end else if (cmd_reg == TN_WONT) begin
                    has_result = 1'b1;
                    res_answer = TN_DONT;
                end
            end
            PH_ESC: begin
                phase_next = PH_DATA;
            end
            default: begin
                if (in_byte_reg == TN_IAC) begin
                    phase_next = PH_CMD;
                end else if (in_byte_reg == TN_ESC) begin
                    phase_next = PH_ESC;
                end else begin
                    has_result = 1'b1;
                end
            end
        endcase
    end

    assign out_free = !out_valid_reg || (m_ready && m_out_last);
    assign consume  = in_valid_reg && (!has_result || out_free);
    assign load     = consume && has_result;
    assign s_ready  = !in_valid_reg || consume;

    assign in_valid_next = (s_valid && s_ready) || (in_valid_reg && !consume);

    always_comb begin
        out_valid_next = out_valid_reg;
        seq_next       = seq_reg;
        if (load) begin
            out_valid_next = 1'b1;
            seq_next       = '0;
        end else if (out_valid_reg && m_ready) begin
            if (m_out_last) begin
                out_valid_next = 1'b0;
            end else begin
                seq_next = seq_reg + SEQ_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            phase_reg     <= PH_DATA;
            cmd_reg       <= '0;
            out_valid_reg <= 1'b0;
            seq_reg       <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            seq_reg       <= seq_next;
            if (consume) begin
                phase_reg <= phase_next;
                cmd_reg   <= cmd_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
        if (load) begin
            kind_reg   <= res_kind;
            byte_reg   <= in_byte_reg;
            answer_reg <= res_answer;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_out_kind = kind_reg;
    assign m_out_last = (kind_reg == KIND_DATA) || (seq_reg == SEQ_W'(REPLY_LEN - 1));

    always_comb begin
        m_out_byte = byte_reg;
        if (kind_reg == KIND_REPLY) begin
            if (seq_reg == SEQ_W'(0)) begin
                m_out_byte = TN_IAC;
            end else if (seq_reg == SEQ_W'(1)) begin
                m_out_byte = answer_reg;
            end
        end
    end

    // assertions
    a_seq_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (seq_reg <= SEQ_W'(REPLY_LEN - 1)))
        else $error("reply index out of range");

    a_data_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && kind_reg == KIND_DATA) |-> (seq_reg == '0))
        else $error("data word with nonzero reply index");

    a_reply_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_out_last) |=>
            (out_valid_reg && seq_reg == $past(seq_reg) + SEQ_W'(1)))
        else $error("reply did not advance to its next word");

    a_cmd_to_opt: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && phase_reg == PH_CMD) |=> (phase_reg == PH_OPT && cmd_reg == $past(in_byte_reg)))
        else $error("command byte not held");

endmodule
